[hw/rtl/mavg_pkg.sv]
// Shared widths, types and codes for the moving average filter.
package mavg_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int CNT_W          = 6;
  localparam int AVG_W          = 24;
  localparam int FRAC_W         = 8;
  localparam int SUM_W          = 27;
  localparam int DEN_W          = 11;
  localparam int DIV_W          = 36;
  localparam int DIV_STEPS      = DIV_W / 2;
  localparam int STEP_W         = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 6;
  localparam int WINDOW_MAX_DEF = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED_MODE = 1'b1;

  localparam logic [CNT_W-1:0] WINDOW_SIZE_RST = 6'd8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_START,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctrl_t;

endpackage

[hw/rtl/moving_average_filter.sv]
// Top level: linear weighted moving average over a ring of sample cells.
//
// Input channel in_valid/in_stall/in_sample carries one signed 16-bit sample per word.
// Output channel out_valid/out_stall carries out_average (signed, 8 fraction bits,
// truncated toward zero) and out_fill_count, one word per input word, in order.
// Config: cfg_we/cfg_index/cfg_data; index 0 window_size, index 1 weighted_mode.
// Writes take effect at the next sample and must be made while the block is idle.
// A sample shifts into the cell ring on acceptance. The ring then rotates once
// around past a running-sum accumulator, then a radix-4 divider forms the quotient.
// One sample is processed at a time: no new sample is taken until the result has
// been loaded into the output register.
// A finished word waits in the output register while the next sample is taken; if it
// is still stalled when the next result is ready, that result holds and in_stall
// stays high. Reset clears the fill count, the output valid and restores
// window_size 8, weighted_mode 1; sample cells are not cleared.
module moving_average_filter import mavg_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [SAMPLE_W-1:0]   in_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [AVG_W-1:0]      out_average,
  output logic        [CNT_W-1:0]      out_fill_count,
  input  logic                         cfg_we,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data
);

  localparam int KW    = $clog2(WINDOW_MAX);
  localparam int WK_W  = (KW > CNT_W) ? KW : CNT_W;
  localparam int CAP_I = (WINDOW_MAX > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : WINDOW_MAX;
  localparam logic [CNT_W-1:0] CAP       = CNT_W'(CAP_I);
  localparam logic [KW-1:0]    WALK_LAST = KW'(WINDOW_MAX - 1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] window_size_r;
  logic             weighted_mode_r;
  logic [CNT_W-1:0] count_r;
  logic [KW-1:0]    k_r;
  logic signed [SUM_W-1:0] acc1_r, acc2_r;
  logic             neg_r;
  logic             out_valid_r;
  logic signed [AVG_W-1:0] average_r;
  logic [CNT_W-1:0] fill_r;

  logic             accept;
  logic [CNT_W-1:0] w_eff, cnt_min, count_nxt;
  cell_ctrl_t       cell_ctrl;
  logic signed [SAMPLE_W-1:0] cell_q [WINDOW_MAX];
  logic signed [SUM_W-1:0]    head, acc1_nxt, numer;
  logic [SUM_W-1:0]           mag;
  logic [2*CNT_W:0]           tri_prod;
  logic [DEN_W-1:0]           den;
  logic [DIV_W-1:0]           div_num;
  logic                       div_start, div_done;
  logic [AVG_W-1:0]           div_quot;
  logic                       load_out;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r   <= WINDOW_SIZE_RST;
      weighted_mode_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE:   window_size_r   <= cfg_data[CNT_W-1:0];
        REG_WEIGHTED_MODE: weighted_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (window_size_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (window_size_r > CAP) begin
      w_eff = CAP;
    end else begin
      w_eff = window_size_r;
    end
    cnt_min   = (count_r > w_eff) ? w_eff : count_r;
    count_nxt = (cnt_min == w_eff) ? w_eff : cnt_min + 1'b1;
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // Sample ring: newest in cell 0 after a shift; rotation brings cell k to cell 0
  assign cell_ctrl.shift  = accept;
  assign cell_ctrl.rotate = (state_r == S_WALK);

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    mavg_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .from_prev ((i == 0) ? in_sample : cell_q[(i + WINDOW_MAX - 1) % WINDOW_MAX]),
      .from_next (cell_q[(i + 1) % WINDOW_MAX]),
      .data      (cell_q[i])
    );
  end

  // Running sums: acc2 accumulates prefix sums, giving weights count..1 newest first
  assign head     = SUM_W'(cell_q[0]);
  assign acc1_nxt = acc1_r + head;

  always_ff @(posedge clk) begin
    if (accept) begin
      acc1_r <= '0;
      acc2_r <= '0;
    end else if (state_r == S_WALK && WK_W'(k_r) < WK_W'(count_r)) begin
      acc1_r <= acc1_nxt;
      acc2_r <= acc2_r + acc1_nxt;
    end
  end

  assign numer    = weighted_mode_r ? acc2_r : acc1_r;
  assign mag      = numer[SUM_W-1] ? SUM_W'(-numer) : SUM_W'(numer);
  assign tri_prod = (2*CNT_W+1)'(count_r) * ((2*CNT_W+1)'(count_r) + 1'b1);
  assign den      = weighted_mode_r ? DEN_W'(tri_prod >> 1) : DEN_W'(count_r);
  assign div_num  = DIV_W'({mag, {FRAC_W{1'b0}}});
  assign div_start = (state_r == S_START);

  mavg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_r <= numer[SUM_W-1];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_WALK;
      S_WALK:  if (k_r == WALK_LAST) state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        count_r <= count_nxt;
        k_r     <= '0;
      end else if (state_r == S_WALK) begin
        k_r <= k_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      average_r <= neg_r ? AVG_W'(-div_quot) : div_quot;
      fill_r    <= count_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_average    = average_r;
  assign out_fill_count = fill_r;

`ifndef SYNTHESIS
  a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_WALK)
    else $error("accepted sample did not start the ring walk");

  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fill_count != '0)
    else $error("result with empty window");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside division state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !load_out)
    else $error("stalled result overwritten");
`endif

endmodule

[hw/rtl/mavg_cell.sv]
// One sample cell of the window ring: shifts in from the previous cell or rotates from the next.
module mavg_cell import mavg_pkg::*; (
  input  logic                       clk,
  input  cell_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] from_prev,
  input  logic signed [SAMPLE_W-1:0] from_next,
  output logic signed [SAMPLE_W-1:0] data
);

  logic signed [SAMPLE_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data_r <= from_prev;
    end else if (ctrl.rotate) begin
      data_r <= from_next;
    end
  end

  assign data = data_r;

endmodule

[hw/rtl/mavg_div.sv]
// Unsigned restoring divider, two quotient bits per cycle.
module mavg_div import mavg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [AVG_W-1:0] quot
);

  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

  logic [DIV_W-1:0]  num_r, num_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;

  always_comb begin
    logic [DEN_W:0] trial;
    rem_nxt = rem_r;
    num_nxt = num_r;
    for (int b = 0; b < 2; b++) begin
      trial   = {rem_nxt, num_nxt[DIV_W-1]};
      num_nxt = {num_nxt[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt    = DEN_W'(trial - {1'b0, den_r});
        num_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[DEN_W-1:0];
      end
    end
  end

  assign done = busy_r && (step_r == DIV_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = num_r[AVG_W-1:0];

endmodule
